@@ src/bus_mouse_port_interface_assert.svh @@
// assertion macros shared by the bus mouse port modules
// no dependencies; include once per asserting file
`ifndef BUS_MOUSE_PORT_INTERFACE_ASSERT_SVH
`define BUS_MOUSE_PORT_INTERFACE_ASSERT_SVH

// same-cycle implication, masked during reset
`define BMPI_ASSERT_NOW(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
      else $error("bmpi assertion failed");

// next-cycle implication, masked during reset
`define BMPI_ASSERT_NEXT(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error("bmpi assertion failed");

`endif

@@ src/bmpi_pkg.sv @@
// shared types and constants for the bus mouse port interface
// no dependencies
package bmpi_pkg;

   // request codes
   localparam logic [2:0] REQ_READ    = 3'd0;
   localparam logic [2:0] REQ_WRITE   = 3'd1;
   localparam logic [2:0] REQ_MOVE    = 3'd2;
   localparam logic [2:0] REQ_PRESS   = 3'd3;
   localparam logic [2:0] REQ_RELEASE = 3'd4;

   // i/o port addresses
   localparam logic [9:0] PORT_DATA = 10'h23c;
   localparam logic [9:0] PORT_SIG  = 10'h23d;
   localparam logic [9:0] PORT_CTRL = 10'h23e;
   localparam logic [9:0] PORT_CFG  = 10'h23f;

   // interrupt control bytes
   localparam logic [7:0] IRQ_OFF_CODE = 8'h10;
   localparam logic [7:0] IRQ_ON_CODE  = 8'h11;

   localparam logic [7:0] SIGNATURE = 8'ha5;

   // data port commands, two encodings each
   localparam logic [7:0] CMD_DX_LO_A = 8'h80;
   localparam logic [7:0] CMD_DX_LO_B = 8'h90;
   localparam logic [7:0] CMD_DX_HI_A = 8'ha0;
   localparam logic [7:0] CMD_DX_HI_B = 8'hb0;
   localparam logic [7:0] CMD_DY_LO_A = 8'hc0;
   localparam logic [7:0] CMD_DY_LO_B = 8'hd0;
   localparam logic [7:0] CMD_DY_HI_A = 8'he0;
   localparam logic [7:0] CMD_DY_HI_B = 8'hf0;

   // button bits
   localparam logic [7:0] LEFT_BIT  = 8'h80;
   localparam logic [7:0] OTHER_BIT = 8'h20;

   typedef struct packed {
      logic [2:0]  req_type;
      logic [9:0]  port;
      logic [7:0]  write_data;
      logic [15:0] pos_x;
      logic [15:0] pos_y;
      logic        button_left;
   } req_item_type;

   typedef struct packed {
      logic [7:0] read_data;
      logic       irq_pulse;
   } rsp_item_type;

endpackage

@@ src/bmpi_core.sv @@
// mouse state registers and the per-word port/event logic
// depends on bmpi_pkg and bus_mouse_port_interface_assert.svh
`include "bus_mouse_port_interface_assert.svh"

module bmpi_core (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   fire,
   input  bmpi_pkg::req_item_type item,
   output bmpi_pkg::rsp_item_type result
);
   import bmpi_pkg::*;

   logic       irq_en_ff,  irq_en_in;
   logic [7:0] command_ff, command_in;
   logic [7:0] button_ff,  button_in;
   // only the low byte of a position ever reaches a delta
   logic [7:0] cur_x_ff,   cur_x_in;
   logic [7:0] cur_y_ff,   cur_y_in;
   logic [7:0] last_x_ff,  last_x_in;
   logic [7:0] last_y_ff,  last_y_in;
   logic [7:0] delta_x_ff, delta_x_in;
   logic [7:0] delta_y_ff, delta_y_in;
   logic [7:0] pattern_ff, pattern_in;
   logic [7:0] mask;

   assign mask = item.button_left ? LEFT_BIT : OTHER_BIT;

   always_comb begin
      irq_en_in        = irq_en_ff;
      command_in       = command_ff;
      button_in        = button_ff;
      cur_x_in         = cur_x_ff;
      cur_y_in         = cur_y_ff;
      last_x_in        = last_x_ff;
      last_y_in        = last_y_ff;
      delta_x_in       = delta_x_ff;
      delta_y_in       = delta_y_ff;
      pattern_in       = pattern_ff;
      result.read_data = 8'h00;
      result.irq_pulse = 1'b0;
      if (fire) begin
         case (item.req_type)
            REQ_READ: begin
               if (item.port == PORT_DATA) begin
                  case (command_ff)
                     CMD_DX_LO_A, CMD_DX_LO_B: begin
                        result.read_data = {4'h0, delta_x_ff[3:0]};
                     end
                     CMD_DX_HI_A, CMD_DX_HI_B: begin
                        result.read_data = {4'h0, delta_x_ff[7:4]};
                        last_x_in        = cur_x_ff;
                     end
                     CMD_DY_LO_A, CMD_DY_LO_B: begin
                        result.read_data = {4'h0, delta_y_ff[3:0]};
                     end
                     CMD_DY_HI_A, CMD_DY_HI_B: begin
                        result.read_data = {4'h0, delta_y_ff[7:4]} | button_ff;
                        last_y_in        = cur_y_ff;
                     end
                     default: begin
                     end
                  endcase
               end else if (item.port == PORT_SIG) begin
                  result.read_data = SIGNATURE;
               end else if (item.port == PORT_CTRL) begin
                  result.read_data = pattern_ff;
                  // one-hot walk, wraps back to bit 0
                  pattern_in       = {pattern_ff[6:0], pattern_ff[7]};
               end
            end
            REQ_WRITE: begin
               if (item.port == PORT_CTRL) begin
                  command_in = item.write_data;
               end else if (item.port == PORT_CFG) begin
                  if (item.write_data == IRQ_OFF_CODE) begin
                     irq_en_in = 1'b0;
                  end else if (item.write_data == IRQ_ON_CODE) begin
                     irq_en_in = 1'b1;
                  end
               end
            end
            REQ_MOVE: begin
               cur_x_in         = item.pos_x[7:0];
               cur_y_in         = item.pos_y[7:0];
               delta_x_in       = item.pos_x[7:0] - last_x_ff;
               delta_y_in       = item.pos_y[7:0] - last_y_ff;
               result.irq_pulse = irq_en_ff;
            end
            REQ_PRESS, REQ_RELEASE: begin
               if (item.req_type == REQ_PRESS) begin
                  button_in = button_ff & ~mask;
               end else begin
                  button_in = button_ff | mask;
               end
               cur_x_in         = item.pos_x[7:0];
               cur_y_in         = item.pos_y[7:0];
               last_x_in        = item.pos_x[7:0];
               last_y_in        = item.pos_y[7:0];
               delta_x_in       = 8'h00;
               delta_y_in       = 8'h00;
               result.irq_pulse = irq_en_ff;
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         irq_en_ff  <= 1'b1;
         command_ff <= 8'h00;
         button_ff  <= 8'h00;
         cur_x_ff   <= 8'h00;
         cur_y_ff   <= 8'h00;
         last_x_ff  <= 8'h00;
         last_y_ff  <= 8'h00;
         delta_x_ff <= 8'h00;
         delta_y_ff <= 8'h00;
         pattern_ff <= 8'h01;
      end else begin
         irq_en_ff  <= irq_en_in;
         command_ff <= command_in;
         button_ff  <= button_in;
         cur_x_ff   <= cur_x_in;
         cur_y_ff   <= cur_y_in;
         last_x_ff  <= last_x_in;
         last_y_ff  <= last_y_in;
         delta_x_ff <= delta_x_in;
         delta_y_ff <= delta_y_in;
         pattern_ff <= pattern_in;
      end
   end

   `BMPI_ASSERT_NOW(a_pattern_onehot, clock, reset, 1'b1, $onehot(pattern_ff))
   `BMPI_ASSERT_NOW(a_button_bits_only, clock, reset, 1'b1, (button_ff & ~(LEFT_BIT | OTHER_BIT)) == 8'h00)
   `BMPI_ASSERT_NEXT(a_button_zeroes_delta, clock, reset, fire && (item.req_type == REQ_PRESS || item.req_type == REQ_RELEASE), delta_x_ff == 8'h00 && delta_y_ff == 8'h00 && last_x_ff == cur_x_ff)
   `BMPI_ASSERT_NEXT(a_idle_holds_state, clock, reset, !fire, $stable(delta_x_ff) && $stable(pattern_ff) && $stable(button_ff))
   `BMPI_ASSERT_NOW(a_irq_needs_enable, clock, reset, result.irq_pulse, fire && irq_en_ff)

endmodule

@@ src/bmpi_rsp_reg.sv @@
// result register with valid/stall handshake toward the consumer
// depends on bmpi_pkg
module bmpi_rsp_reg (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   load_valid,
   input  bmpi_pkg::rsp_item_type load_data,
   output logic                   load_ready,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output bmpi_pkg::rsp_item_type rsp_data
);
   import bmpi_pkg::*;

   logic         valid_ff, valid_in;
   rsp_item_type data_ff,  data_in;

   // room when empty or when the held word leaves this cycle
   assign load_ready = !valid_ff || !rsp_stall;

   always_comb begin
      valid_in = valid_ff;
      data_in  = data_ff;
      if (load_ready) begin
         valid_in = load_valid;
         data_in  = load_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign rsp_valid = valid_ff;
   assign rsp_data  = data_ff;

endmodule

@@ src/bus_mouse_port_interface.sv @@
// bus mouse port interface: an accepted word is held in the input register, then moves
// on to the result register, from which it can leave
// throughput one word per cycle while rsp_stall is low; input register -> event logic -> result register
// req_stall rises only while a full input register cannot move on (rsp stalled)
// reset (synchronous, active high) empties both registers and restores the
// mouse state: irq enabled, pattern 0x01, everything else zero
`include "bus_mouse_port_interface_assert.svh"

module bus_mouse_port_interface (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [2:0]  req_type,
   input  logic [9:0]  req_port,
   input  logic [7:0]  req_write_data,
   input  logic [15:0] req_pos_x,
   input  logic [15:0] req_pos_y,
   input  logic        req_button_left,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [7:0]  rsp_read_data,
   output logic        rsp_irq_pulse
);
   import bmpi_pkg::*;

   // input register stage
   logic         in_valid_ff, in_valid_in;
   req_item_type in_item_ff,  in_item_in;
   req_item_type req_item;

   // handshake between stages
   logic         load_ready;
   logic         advance;
   logic         req_accept;
   rsp_item_type core_result;
   rsp_item_type rsp_data;

   assign req_item.req_type    = req_type;
   assign req_item.port        = req_port;
   assign req_item.write_data  = req_write_data;
   assign req_item.pos_x       = req_pos_x;
   assign req_item.pos_y       = req_pos_y;
   assign req_item.button_left = req_button_left;

   // a held word moves to the result register when that register has room;
   // the mouse state commits on the same edge
   assign advance    = in_valid_ff && load_ready;
   // input register takes a new word when empty or emptying
   assign req_stall  = in_valid_ff && !load_ready;
   assign req_accept = req_valid && !req_stall;

   always_comb begin
      in_valid_in = in_valid_ff;
      in_item_in  = in_item_ff;
      if (!req_stall) begin
         in_valid_in = req_valid;
         in_item_in  = req_item;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   // payload needs no reset
   always_ff @(posedge clock) begin
      in_item_ff <= in_item_in;
   end

   // port reads, writes and mouse events against the stored mouse state
   bmpi_core u_core (
      .clock  (clock),
      .reset  (reset),
      .fire   (advance),
      .item   (in_item_ff),
      .result (core_result)
   );

   // result register, takes a new word when empty or when its held word leaves
   bmpi_rsp_reg u_rsp_reg (
      .clock      (clock),
      .reset      (reset),
      .load_valid (in_valid_ff),
      .load_data  (core_result),
      .load_ready (load_ready),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_data   (rsp_data)
   );

   assign rsp_read_data = rsp_data.read_data;
   assign rsp_irq_pulse = rsp_data.irq_pulse;

   // an accepted word always lands in the input register
   `BMPI_ASSERT_NEXT(a_accept_loads, clock, reset, req_accept, in_valid_ff)
   // a word left in a stalled input register stays put
   `BMPI_ASSERT_NEXT(a_hold_when_blocked, clock, reset, in_valid_ff && !load_ready, in_valid_ff && $stable(in_item_ff))
   // a word moved forward shows up as a result
   `BMPI_ASSERT_NEXT(a_advance_shows, clock, reset, advance, rsp_valid)

endmodule
